>>> design/kvf_pkg.sv
// shared types, constants and helper functions of the altitude and vario filter
`timescale 1ns / 1ps

package kvf_pkg;

	// largest magnitude kept by products and gains
	localparam logic [63:0] LIM62 = 64'h3FFF_FFFF_FFFF_FFFF;

	// post-multiply shift codes
	localparam logic [2:0] SH_0  = 3'd0;
	localparam logic [2:0] SH_16 = 3'd1;
	localparam logic [2:0] SH_32 = 3'd2;
	localparam logic [2:0] SH_34 = 3'd3;
	localparam logic [2:0] SH_49 = 3'd4;

	// saturation bounds
	localparam logic signed [65:0] MAX32 = 66'sd2147483647;
	localparam logic signed [65:0] MIN32 = -66'sd2147483648;
	localparam logic signed [65:0] MAX48 = 66'sd140737488355327;
	localparam logic signed [65:0] MIN48 = -66'sd140737488355328;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] measured_alt;
		logic [15:0]        time_step;
	} kvf_in_t;

	typedef struct packed {
		logic signed [31:0] altitude;
		logic signed [31:0] vertical_speed;
	} kvf_out_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic [2:0]         sh;
	} kvf_mul_req_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] n;
		logic signed [63:0] s;
	} kvf_div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] value;
	} kvf_res_t;

	function automatic logic [6:0] shift_amount(input logic [2:0] code);
		logic [6:0] amt;
		unique case (code)
			SH_0:    amt = 7'd0;
			SH_16:   amt = 7'd16;
			SH_32:   amt = 7'd32;
			SH_34:   amt = 7'd34;
			SH_49:   amt = 7'd49;
			default: amt = 7'd0;
		endcase
		return amt;
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > MAX32) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < MIN32) begin
			r = 32'sh8000_0000;
		end else begin
			r = $signed(v[31:0]);
		end
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
		logic signed [47:0] r;
		if (v > MAX48) begin
			r = 48'sh7FFF_FFFF_FFFF;
		end else if (v < MIN48) begin
			r = 48'sh8000_0000_0000;
		end else begin
			r = $signed(v[47:0]);
		end
		return r;
	endfunction

endpackage

>>> design/kvf_mul.sv
// iterative signed multiplier with rounding shift and saturation
`timescale 1ns / 1ps

module kvf_mul import kvf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  kvf_mul_req_t req,
	output kvf_res_t     res
);

	localparam logic [2:0] LAST_PHASE = 3'd4;

	logic               busy_q;
	logic               done_q;
	logic               neg_q;
	logic [2:0]         phase_q;
	logic [2:0]         sh_q;
	logic [63:0]        ua_q;
	logic [63:0]        ub_q;
	logic [127:0]       acc_q;
	logic signed [63:0] val_q;

	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [63:0]  pp;
	logic [1:0]   pos;
	logic [127:0] pp_shifted;
	logic [6:0]   amt;
	logic [127:0] rnd;
	logic [127:0] rounded;
	logic [127:0] shifted;
	logic [63:0]  mag_r;

	// one 32x32 partial product per cycle
	always_comb begin
		a_half     = phase_q[1] ? ua_q[63:32] : ua_q[31:0];
		b_half     = phase_q[0] ? ub_q[63:32] : ub_q[31:0];
		pp         = a_half * b_half;
		pos        = {1'b0, phase_q[1]} + {1'b0, phase_q[0]};
		pp_shifted = {64'b0, pp} << {pos, 5'b0};
	end

	// round half away from zero, shift, clamp
	always_comb begin
		amt     = shift_amount(sh_q);
		rnd     = (amt == 7'd0) ? 128'd0 : (128'd1 << (amt - 7'd1));
		rounded = acc_q + rnd;
		shifted = rounded >> amt;
		mag_r   = (shifted[127:62] != '0) ? LIM62 : {2'b00, shifted[61:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ua_q    <= mag(req.a);
				ub_q    <= mag(req.b);
				neg_q   <= req.a[63] ^ req.b[63];
				sh_q    <= req.sh;
				acc_q   <= '0;
				phase_q <= '0;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				if (phase_q != LAST_PHASE) begin
					acc_q   <= acc_q + pp_shifted;
					phase_q <= phase_q + 3'd1;
				end else begin
					val_q  <= neg_q ? -$signed(mag_r) : $signed(mag_r);
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign res.done  = done_q;
	assign res.value = val_q;

endmodule

>>> design/kvf_div.sv
// bit-serial gain divider, 32 fraction bits, truncated and saturated
`timescale 1ns / 1ps

module kvf_div import kvf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  kvf_div_req_t req,
	output kvf_res_t     res
);

	localparam logic [5:0] LAST_BIT = 6'd61;

	logic               busy_q;
	logic               done_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic [48:0]        us_q;
	logic [48:0]        rem_q;
	logic [61:0]        dsh_q;
	logic [61:0]        quo_q;
	logic signed [63:0] val_q;

	logic [63:0] un_full;
	logic [47:0] un_in;
	logic [48:0] us_in;
	logic        sat_in;
	logic [49:0] trial;
	logic        ge;
	logic [48:0] rem_n;
	logic [61:0] quo_n;
	logic [63:0] quo_ext;

	// integer part at or above 2^30 saturates
	always_comb begin
		un_full = mag(req.n);
		un_in   = un_full[47:0];
		us_in   = req.s[48:0];
		sat_in  = {31'b0, un_in} >= {us_in, 30'b0};
	end

	// one restoring step per cycle
	always_comb begin
		trial   = {rem_q, dsh_q[61]};
		ge      = trial >= {1'b0, us_q};
		rem_n   = ge ? 49'(trial - {1'b0, us_q}) : trial[48:0];
		quo_n   = {quo_q[60:0], ge};
		quo_ext = {2'b00, quo_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				neg_q <= req.n[63];
				if (sat_in) begin
					val_q  <= req.n[63] ? -$signed(LIM62) : $signed(LIM62);
					done_q <= 1'b1;
				end else begin
					us_q   <= us_in;
					rem_q  <= {31'b0, un_in[47:30]};
					dsh_q  <= {un_in[29:0], 32'b0};
					quo_q  <= '0;
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				dsh_q <= {dsh_q[60:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST_BIT) begin
					val_q  <= neg_q ? -$signed(quo_ext) : $signed(quo_ext);
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign res.done  = done_q;
	assign res.value = val_q;

endmodule

>>> design/altitude_vario_kalman_filter.sv
// top level of the two-state altitude and vertical speed filter
`timescale 1ns / 1ps

// Two-state constant-velocity filter for a barometric altimeter. Each item either
// filters a new altitude sample over its time step or sets the altitude and clears
// the altitude variance; every item yields one result with the filtered altitude and
// vertical speed. A filter item runs on a small sequencer over one shared multiplier
// (four 32x32 partial products per product step) and one bit-serial divider for the
// two gains, which yields one quotient bit per cycle; with a non-positive innovation
// variance the gains are skipped. A new item is taken while the previous result
// still waits in the output register.
module altitude_vario_kalman_filter import kvf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  kvf_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output kvf_out_t    out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic REG_ACCEL = 1'b0;
	localparam logic REG_MEAS  = 1'b1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	localparam logic [3:0] STEP_D2  = 4'd0;
	localparam logic [3:0] STEP_D3  = 4'd1;
	localparam logic [3:0] STEP_QD2 = 4'd2;
	localparam logic [3:0] STEP_QD3 = 4'd3;
	localparam logic [3:0] STEP_QD4 = 4'd4;
	localparam logic [3:0] STEP_ALT = 4'd5;
	localparam logic [3:0] STEP_DV  = 4'd6;
	localparam logic [3:0] STEP_P00 = 4'd7;
	localparam logic [3:0] STEP_K0  = 4'd8;
	localparam logic [3:0] STEP_K1  = 4'd9;
	localparam logic [3:0] STEP_CA  = 4'd10;
	localparam logic [3:0] STEP_CS  = 4'd11;
	localparam logic [3:0] STEP_CPP = 4'd12;
	localparam logic [3:0] STEP_CPV = 4'd13;
	localparam logic [3:0] STEP_CVV = 4'd14;

	logic [1:0]  state_q;
	logic [3:0]  step_q;
	logic        out_valid_q;
	kvf_out_t    out_q;
	logic [31:0] q_q;
	logic [31:0] r_q;

	// filter state
	logic signed [31:0] alt_q;
	logic signed [31:0] spd_q;
	logic signed [47:0] cpp_q;
	logic signed [47:0] cpv_q;
	logic signed [47:0] cvv_q;

	// per-item working values
	logic signed [31:0] meas_q;
	logic [15:0]        d_q;
	logic [31:0]        d2_q;
	logic [47:0]        d3_q;
	logic [32:0]        qd2_q;
	logic [31:0]        qd3h_q;
	logic [31:0]        qd4q_q;
	logic signed [49:0] inner_q;
	logic signed [47:0] p00_q;
	logic signed [47:0] p01_q;
	logic signed [47:0] p11_q;
	logic signed [32:0] y_q;
	logic signed [49:0] s_q;
	logic signed [63:0] k0_q;
	logic signed [63:0] k1_q;

	kvf_mul_req_t mul_req;
	kvf_div_req_t div_req;
	kvf_res_t     mul_res;
	kvf_res_t     div_res;

	logic               unit_done;
	logic signed [63:0] rv;
	logic signed [63:0] dx;
	logic signed [63:0] qx;
	logic signed [63:0] d2x;
	logic signed [63:0] yx;
	logic signed [65:0] inner_sum;
	logic signed [47:0] p00_n;
	logic signed [47:0] p11_n;
	logic signed [49:0] s_n;
	logic signed [32:0] y_n;
	logic               use_div;

	kvf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.res    (mul_res)
	);

	kvf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	assign unit_done = mul_res.done | div_res.done;
	assign rv        = mul_res.done ? mul_res.value : div_res.value;

	// operand selection per sequencer step
	always_comb begin
		dx      = $signed({48'b0, d_q});
		qx      = $signed({32'b0, q_q});
		d2x     = $signed({32'b0, d2_q});
		yx      = 64'(y_q);
		use_div = 1'b0;
		mul_req = '0;
		div_req = '0;
		unique case (step_q)
			STEP_D2: begin
				mul_req.a = dx; mul_req.b = dx; mul_req.sh = SH_0;
			end
			STEP_D3: begin
				mul_req.a = d2x; mul_req.b = dx; mul_req.sh = SH_0;
			end
			STEP_QD2: begin
				mul_req.a = qx; mul_req.b = d2x; mul_req.sh = SH_32;
			end
			STEP_QD3: begin
				mul_req.a = qx; mul_req.b = $signed({16'b0, d3_q}); mul_req.sh = SH_49;
			end
			STEP_QD4: begin
				mul_req.a = $signed({31'b0, qd2_q}); mul_req.b = d2x; mul_req.sh = SH_34;
			end
			STEP_ALT: begin
				mul_req.a = dx; mul_req.b = 64'(spd_q); mul_req.sh = SH_16;
			end
			STEP_DV: begin
				mul_req.a = dx; mul_req.b = 64'(cvv_q); mul_req.sh = SH_16;
			end
			STEP_P00: begin
				mul_req.a = dx; mul_req.b = 64'(inner_q); mul_req.sh = SH_16;
			end
			STEP_K0: begin
				use_div = 1'b1; div_req.n = 64'(p00_q); div_req.s = 64'(s_q);
			end
			STEP_K1: begin
				use_div = 1'b1; div_req.n = 64'(p01_q); div_req.s = 64'(s_q);
			end
			STEP_CA: begin
				mul_req.a = k0_q; mul_req.b = yx; mul_req.sh = SH_32;
			end
			STEP_CS: begin
				mul_req.a = k1_q; mul_req.b = yx; mul_req.sh = SH_32;
			end
			STEP_CPP: begin
				mul_req.a = k0_q; mul_req.b = 64'(p00_q); mul_req.sh = SH_32;
			end
			STEP_CPV: begin
				mul_req.a = k0_q; mul_req.b = 64'(p01_q); mul_req.sh = SH_32;
			end
			STEP_CVV: begin
				mul_req.a = k1_q; mul_req.b = 64'(p01_q); mul_req.sh = SH_32;
			end
			default: begin
				mul_req.sh = SH_0;
			end
		endcase
		mul_req.start = (state_q == ST_ISSUE) && !use_div;
		div_req.start = (state_q == ST_ISSUE) && use_div;
	end

	// predicted covariance, innovation and its variance
	always_comb begin
		inner_sum = 66'(rv) + (66'(cpv_q) <<< 1);
		p00_n     = sat48(66'(cpp_q) + 66'(rv) + 66'($signed({1'b0, qd4q_q})));
		p11_n     = sat48(66'(cvv_q) + 66'($signed({1'b0, qd2_q})));
		s_n       = 50'(p00_n) + $signed({18'b0, r_q});
		y_n       = 33'(meas_q) - 33'(alt_q);
	end

	// sequencer, state update and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_D2;
			out_valid_q <= 1'b0;
			q_q         <= 32'd65536;
			r_q         <= 32'd65536;
			alt_q       <= '0;
			spd_q       <= '0;
			cpp_q       <= '0;
			cpv_q       <= '0;
			cvv_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACCEL: q_q <= cfg_data;
					REG_MEAS:  r_q <= cfg_data;
					default:   q_q <= q_q;
				endcase
			end
			// result valid is set on load and cleared when taken
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						meas_q <= in_data.measured_alt;
						d_q    <= in_data.time_step;
						if (in_data.operation) begin
							alt_q   <= in_data.measured_alt;
							cpp_q   <= '0;
							state_q <= ST_OUT;
						end else begin
							step_q  <= STEP_D2;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (unit_done) begin
						step_q  <= step_q + 4'd1;
						state_q <= ST_ISSUE;
						unique case (step_q)
							STEP_D2:  d2_q   <= rv[31:0];
							STEP_D3:  d3_q   <= rv[47:0];
							STEP_QD2: qd2_q  <= rv[32:0];
							STEP_QD3: qd3h_q <= rv[31:0];
							STEP_QD4: qd4q_q <= rv[31:0];
							STEP_ALT: alt_q  <= sat32(66'(alt_q) + 66'(rv));
							STEP_DV: begin
								inner_q <= $signed(inner_sum[49:0]);
								p01_q   <= sat48(66'(cpv_q) + 66'(rv)
									+ 66'($signed({1'b0, qd3h_q})));
							end
							STEP_P00: begin
								p00_q <= p00_n;
								p11_q <= p11_n;
								y_q   <= y_n;
								s_q   <= s_n;
								// non-positive innovation variance skips the correction
								if (s_n[49] || s_n == '0) begin
									cpp_q   <= p00_n;
									cpv_q   <= p01_q;
									cvv_q   <= p11_n;
									state_q <= ST_OUT;
								end
							end
							STEP_K0:  k0_q  <= rv;
							STEP_K1:  k1_q  <= rv;
							STEP_CA:  alt_q <= sat32(66'(alt_q) + 66'(rv));
							STEP_CS:  spd_q <= sat32(66'(spd_q) + 66'(rv));
							STEP_CPP: cpp_q <= sat48(66'(p00_q) - 66'(rv));
							STEP_CPV: cpv_q <= sat48(66'(p01_q) - 66'(rv));
							STEP_CVV: begin
								cvv_q   <= sat48(66'(p11_q) - 66'(rv));
								state_q <= ST_OUT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_q.altitude       <= alt_q;
						out_q.vertical_speed <= spd_q;
						state_q              <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
